/* hw/rtl/atbb_pkg.sv */
// shared types and constants for the affine bounding box transform
package atbb_pkg;

    // number of transform rows and register map
    localparam int NUM_ROWS = 3;
    localparam int AXES     = 3;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Z = 2'd2;

    // reset values form the identity transform
    localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

    // input word: source box corners, signed q8.8
    typedef struct packed {
        logic signed [15:0] box_min_x;
        logic signed [15:0] box_min_y;
        logic signed [15:0] box_min_z;
        logic signed [15:0] box_max_x;
        logic signed [15:0] box_max_y;
        logic signed [15:0] box_max_z;
    } box_in_t;

    // output word: bounding box corners, signed q8.8
    typedef struct packed {
        logic signed [15:0] out_min_x;
        logic signed [15:0] out_min_y;
        logic signed [15:0] out_min_z;
        logic signed [15:0] out_max_x;
        logic signed [15:0] out_max_y;
        logic signed [15:0] out_max_z;
    } box_out_t;

    // one transform row as packed in its register
    typedef struct packed {
        logic signed [15:0] t;
        logic signed [15:0] cz;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } coef_t;

    // per-axis extreme products of one row, q16.16, plus translation
    typedef struct packed {
        logic [AXES-1:0][31:0] min_p;
        logic [AXES-1:0][31:0] max_p;
        logic signed [15:0]    t;
    } prod_t;

endpackage

/* hw/rtl/affine_transform_bounding_box_core.sv */
// top level: affine transform of an axis-aligned bounding box
//
// Takes one box word per cycle and returns the axis-aligned box that bounds its
// eight corners after the affine transform in the three row registers. The min
// and max of each output axis are found per source axis by choosing the right end
// of the box for each coefficient, so no corner enumeration is needed. The path is
// a three-stage pipeline: input register, a product register fed by eighteen
// 16x16 multipliers, and the result register after summing, rounding and
// saturation. The input register loads at the accepting edge, and the word then
// passes through the product register to the result register, where out_valid rises; a new word
// can be accepted every cycle while no output stall backs up to the input; stalls on the output back up
// stage by stage, with empty stages filled while the result waits.
module affine_transform_bounding_box_core
    import atbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  box_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output box_out_t          out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    coef_t              rows [NUM_ROWS];
    box_in_t            box_reg;
    logic               v0_reg;
    logic               v1_reg;
    logic               out_valid_reg;
    box_out_t           out_data_reg;
    box_out_t           out_data_next;
    prod_t              prod [NUM_ROWS];
    logic signed [15:0] row_min [NUM_ROWS];
    logic signed [15:0] row_max [NUM_ROWS];
    logic               en0;
    logic               en1;
    logic               en2;

    // configuration registers
    atbb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows)
    );

    // stage enables: a stage moves when it is empty or the next one moves
    assign en2      = !out_valid_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    // input register
    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
        begin
            box_reg <= in_data;
        end
    end

    // per-row datapath
    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        atbb_row_mult u_mult (
            .clk  (clk),
            .en   (en1 && v0_reg),
            .box  (box_reg),
            .coef (rows[r]),
            .prod (prod[r])
        );

        atbb_row_reduce u_reduce (
            .prod  (prod[r]),
            .min_q (row_min[r]),
            .max_q (row_max[r])
        );
    end

    // result word assembly
    always_comb
    begin
        out_data_next.out_min_x = row_min[REG_ROW_X];
        out_data_next.out_min_y = row_min[REG_ROW_Y];
        out_data_next.out_min_z = row_min[REG_ROW_Z];
        out_data_next.out_max_x = row_max[REG_ROW_X];
        out_data_next.out_max_y = row_max[REG_ROW_Y];
        out_data_next.out_max_z = row_max[REG_ROW_Z];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= in_valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
            end
            if (en2)
            begin
                out_valid_reg <= v1_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/atbb_apb_regs.sv */
// apb register file holding the three transform rows
module atbb_apb_regs
    import atbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    output coef_t                 rows [NUM_ROWS]
);

    logic [63:0]      rows_reg [NUM_ROWS];
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[REG_ROW_X] <= ROW_X_RESET;
            rows_reg[REG_ROW_Y] <= ROW_Y_RESET;
            rows_reg[REG_ROW_Z] <= ROW_Z_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROW_X: rows_reg[REG_ROW_X] <= pwdata;
                REG_ROW_Y: rows_reg[REG_ROW_Y] <= pwdata;
                REG_ROW_Z: rows_reg[REG_ROW_Z] <= pwdata;
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_ROW_X: prdata = rows_reg[REG_ROW_X];
            REG_ROW_Y: prdata = rows_reg[REG_ROW_Y];
            REG_ROW_Z: prdata = rows_reg[REG_ROW_Z];
            default:   prdata = '0;
        endcase
    end

    // present rows as coefficient structs
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            rows[r] = coef_t'(rows_reg[r]);
        end
    end

endmodule

/* hw/rtl/atbb_row_mult.sv */
// per-row product stage: picks the extreme corner per axis and multiplies
module atbb_row_mult
    import atbb_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  box_in_t box,
    input  coef_t   coef,
    output prod_t   prod
);

    logic signed [15:0] lo [AXES];
    logic signed [15:0] hi [AXES];
    logic signed [15:0] c  [AXES];
    logic signed [15:0] min_op [AXES];
    logic signed [15:0] max_op [AXES];
    prod_t              prod_next;
    prod_t              prod_reg;

    assign lo[0] = box.box_min_x;
    assign lo[1] = box.box_min_y;
    assign lo[2] = box.box_min_z;
    assign hi[0] = box.box_max_x;
    assign hi[1] = box.box_max_y;
    assign hi[2] = box.box_max_z;
    assign c[0]  = coef.cx;
    assign c[1]  = coef.cy;
    assign c[2]  = coef.cz;

    // a negative coefficient or an inverted axis swaps which end is smaller
    always_comb
    begin
        prod_next.t = coef.t;
        for (int a = 0; a < AXES; a++)
        begin
            if (c[a][15] ^ (lo[a] > hi[a]))
            begin
                min_op[a] = hi[a];
                max_op[a] = lo[a];
            end
            else
            begin
                min_op[a] = lo[a];
                max_op[a] = hi[a];
            end
            prod_next.min_p[a] = c[a] * min_op[a];
            prod_next.max_p[a] = c[a] * max_op[a];
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/atbb_row_reduce.sv */
// per-row sum, round half up to q8.8 and saturate
module atbb_row_reduce
    import atbb_pkg::*;
(
    input  prod_t              prod,
    output logic signed [15:0] min_q,
    output logic signed [15:0] max_q
);

    logic signed [33:0] t_ext;
    logic signed [33:0] sum_min;
    logic signed [33:0] sum_max;

    function automatic logic signed [33:0] sext(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [33:0] v);
        logic signed [33:0] biased;
        logic signed [25:0] r;
        biased = v + 34'sd128;
        r      = biased[33:8];
        if (r > 26'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (r < -26'sd32768)
        begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    // translation widened to q16.16
    assign t_ext = {{10{prod.t[15]}}, prod.t, 8'h00};

    assign sum_min = sext(prod.min_p[0]) + sext(prod.min_p[1]) + sext(prod.min_p[2]) + t_ext;
    assign sum_max = sext(prod.max_p[0]) + sext(prod.max_p[1]) + sext(prod.max_p[2]) + t_ext;

    assign min_q = round_sat(sum_min);
    assign max_q = round_sat(sum_max);

endmodule

/* sim/tb_top.sv */
// testbench for the affine bounding box core: directed table, random boxes, apb register sweep
`timescale 1ns / 1ps

module tb_top;
    import atbb_pkg::*;

    localparam int PIPE_LAT    = 3;
    localparam int DIR_ROWS    = 17;
    localparam int SEG_ITEMS   = 154;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // how a random transform row is drawn
    typedef enum int {
        ROWS_FULL,
        ROWS_SMALL,
        ROWS_EXTREME,
        ROWS_PERM
    } row_mode_e;

    // how a random box is drawn
    typedef enum int {
        BOX_ORDERED,
        BOX_FULL,
        BOX_EXTREME
    } box_mode_e;

    // one row of the directed table
    typedef struct packed {
        logic [2:0] cfg_id;
        logic       chk;
        box_in_t    stim;
        box_out_t   want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    box_in_t           in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    box_out_t          out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0]       pwdata = '0;
    logic [63:0]       prdata;
    logic              pready;

    // shadow of the transform rows used for prediction
    logic [63:0] xform_rows [NUM_ROWS];
    box_out_t    expected_boxes [$];

    dir_row_t    dir_tab [DIR_ROWS];
    logic [63:0] dir_cfg [6][NUM_ROWS];

    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;
    int          err_count = 0;
    int          item_count = 0;
    int          result_count = 0;
    int          cfg_count = 0;
    int unsigned cyc_count = 0;

    string fld_names [6] = '{"out_max_z", "out_max_y", "out_max_x",
                             "out_min_z", "out_min_y", "out_min_x"};

    affine_transform_bounding_box_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cyc_count++;
        if (cyc_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver side back pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // compare each delivered word with the oldest prediction
    always @(posedge clk)
    begin
        box_out_t         want;
        logic [5:0][15:0] w;
        logic [5:0][15:0] g;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected word %h", $time, out_data);
            end
            else
            begin
                want = expected_boxes.pop_front();
                w = want;
                g = out_data;
                for (int f = 5; f >= 0; f--)
                begin
                    if (w[f] !== g[f])
                    begin
                        err_count++;
                        $display("%0t: %s expected %0d got %0d", $time, fld_names[f],
                                 $signed(w[f]), $signed(g[f]));
                    end
                end
                result_count++;
            end
        end
    end

    function automatic logic [95:0] mk6(input logic [15:0] a, b, c, d, e, f);
        return {a, b, c, d, e, f};
    endfunction

    function automatic logic [63:0] pack_row(input logic [15:0] cx, cy, cz, t);
        return {t, cz, cy, cx};
    endfunction

    function automatic logic [ADDR_W-1:0] reg_addr(input logic [IDX_W-1:0] idx);
        return {idx, 3'b000};
    endfunction

    // q16.16 to q8.8, round half up, saturate
    function automatic logic [15:0] round_q88(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // bounding box of the eight transformed corners
    function automatic box_out_t bound_box(input box_in_t b);
        longint      lo [3];
        longint      hi [3];
        longint      v, mn, mx, px, py, pz;
        logic [15:0] lo_q [3];
        logic [15:0] hi_q [3];
        coef_t       row;
        lo[0] = longint'(b.box_min_x);
        lo[1] = longint'(b.box_min_y);
        lo[2] = longint'(b.box_min_z);
        hi[0] = longint'(b.box_max_x);
        hi[1] = longint'(b.box_max_y);
        hi[2] = longint'(b.box_max_z);
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = coef_t'(xform_rows[r]);
            mn = 0;
            mx = 0;
            for (int c = 0; c < 8; c++)
            begin
                px = (c & 1) ? hi[0] : lo[0];
                py = (c & 2) ? hi[1] : lo[1];
                pz = (c & 4) ? hi[2] : lo[2];
                v = longint'(row.cx) * px + longint'(row.cy) * py +
                    longint'(row.cz) * pz + longint'(row.t) * 256;
                if (c == 0 || v < mn)
                    mn = v;
                if (c == 0 || v > mx)
                    mx = v;
            end
            lo_q[r] = round_q88(mn);
            hi_q[r] = round_q88(mx);
        end
        return mk6(lo_q[0], lo_q[1], lo_q[2], hi_q[0], hi_q[1], hi_q[2]);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0001;
            4: return 16'hFFFF;
            default: return 16'h0100;
        endcase
    endfunction

    function automatic logic [63:0] rand_row(input row_mode_e mode);
        logic [15:0] f [4];
        for (int k = 0; k < 4; k++)
            f[k] = '0;
        case (mode)
            ROWS_FULL:
            begin
                for (int k = 0; k < 4; k++)
                    f[k] = 16'($urandom);
            end
            ROWS_SMALL:
            begin
                for (int k = 0; k < 3; k++)
                    f[k] = 16'($urandom_range(0, 1023)) - 16'd512;
                f[3] = 16'($urandom_range(0, 16383)) - 16'd8192;
            end
            ROWS_EXTREME:
            begin
                for (int k = 0; k < 4; k++)
                    f[k] = pick_extreme();
            end
            default:
            begin
                f[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'h0100 : 16'hFF00;
                f[3] = 16'($urandom_range(0, 2047)) - 16'd1024;
            end
        endcase
        return pack_row(f[0], f[1], f[2], f[3]);
    endfunction

    function automatic box_in_t rand_box();
        logic [15:0] lo [3];
        logic [15:0] hi [3];
        int          pick;
        box_mode_e   mode;
        pick = $urandom_range(0, 99);
        mode = (pick < 60) ? BOX_ORDERED : (pick < 80) ? BOX_FULL : BOX_EXTREME;
        for (int a = 0; a < 3; a++)
        begin
            case (mode)
                BOX_ORDERED:
                begin
                    lo[a] = 16'($urandom_range(0, 16383)) - 16'd8192;
                    hi[a] = lo[a] + 16'($urandom_range(0, 2048));
                end
                BOX_FULL:
                begin
                    lo[a] = 16'($urandom);
                    hi[a] = 16'($urandom);
                end
                default:
                begin
                    lo[a] = pick_extreme();
                    hi[a] = pick_extreme();
                end
            endcase
        end
        return mk6(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // one apb transfer, setup then access, followed by an idle phase with psel low
    task automatic apb_xfer(input logic wr, input logic [IDX_W-1:0] idx,
                            input logic [63:0] wdata, output logic [63:0] rdata);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= reg_addr(idx);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = pready;
            rdata = prdata;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // read back every row and compare with the shadow copy
    task automatic check_rows();
        logic [63:0] rd;
        for (int k = 0; k < NUM_ROWS; k++)
        begin
            apb_xfer(1'b0, IDX_W'(k), 64'd0, rd);
            if (rd !== xform_rows[k])
            begin
                err_count++;
                $display("%0t: row %0d readback expected %h got %h", $time, k,
                         xform_rows[k], rd);
            end
        end
    endtask

    // load a new transform, poke the unused slot, then read back
    task automatic apply_rows(input logic [63:0] rx, ry, rz);
        logic [63:0] rd;
        apb_xfer(1'b1, REG_ROW_X, rx, rd);
        xform_rows[REG_ROW_X] = rx;
        apb_xfer(1'b1, REG_ROW_Y, ry, rd);
        xform_rows[REG_ROW_Y] = ry;
        apb_xfer(1'b1, REG_ROW_Z, rz, rd);
        xform_rows[REG_ROW_Z] = rz;
        apb_xfer(1'b1, REG_UNUSED, {$urandom, $urandom}, rd);
        check_rows();
        cfg_count++;
    endtask

    // offer one box word and record its expected bounding box on acceptance
    task automatic send_box(input box_in_t b, input logic chk, input box_out_t want);
        logic ok;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end
        expected_boxes.push_back(chk ? want : bound_box(b));
        item_count++;
    endtask

    // stop sending and let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    initial
    begin
        int cur;
        xform_rows[REG_ROW_X] = ROW_X_RESET;
        xform_rows[REG_ROW_Y] = ROW_Y_RESET;
        xform_rows[REG_ROW_Z] = ROW_Z_RESET;

        // directed settings: identity, rounding ties, all max, all min, zero, near saturation
        dir_cfg[0] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
        dir_cfg[1] = '{pack_row(16'h0080, 16'h0000, 16'h0000, 16'h0000),
                       pack_row(16'h0000, 16'hFF80, 16'h0000, 16'h0000),
                       pack_row(16'h0000, 16'h0000, 16'h0080, 16'h0001)};
        dir_cfg[2] = '{pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                       pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                       pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF)};
        dir_cfg[3] = '{pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                       pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000),
                       pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000)};
        dir_cfg[4] = '{64'd0, 64'd0, 64'd0};
        dir_cfg[5] = '{pack_row(16'h0100, 16'h0000, 16'h0000, 16'h7F00),
                       pack_row(16'h0000, 16'h0100, 16'h0000, 16'h8100),
                       pack_row(16'h0100, 16'h0100, 16'h0100, 16'h0000)};

        // directed table; want is typed in only where chk is set
        dir_tab[0]  = {3'd0, 1'b1, mk6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
                                   mk6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000)};
        dir_tab[1]  = {3'd0, 1'b1, mk6(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                                   mk6(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF)};
        // inverted box still bounds all eight corners
        dir_tab[2]  = {3'd0, 1'b1, mk6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000),
                                   mk6(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF)};
        dir_tab[3]  = {3'd0, 1'b1, mk6(16'hFE80, 16'h0040, 16'hFFFF, 16'h0200, 16'h0041, 16'h0001),
                                   mk6(16'hFE80, 16'h0040, 16'hFFFF, 16'h0200, 16'h0041, 16'h0001)};
        dir_tab[4]  = {3'd0, 1'b0, mk6(16'h0300, 16'h8000, 16'h1234, 16'h0100, 16'h7FFF, 16'h1234),
                                   96'd0};
        // half lsb products: ties go up on both signs
        dir_tab[5]  = {3'd1, 1'b1, mk6(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001),
                                   mk6(16'h0001, 16'h0000, 16'h0002, 16'h0001, 16'h0000, 16'h0002)};
        dir_tab[6]  = {3'd1, 1'b0, mk6(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0003, 16'h0003, 16'h0003),
                                   96'd0};
        dir_tab[7]  = {3'd1, 1'b0, mk6(16'h8000, 16'h8001, 16'hFF00, 16'h7FFF, 16'h7FFE, 16'h0100),
                                   96'd0};
        // saturation on both ends
        dir_tab[8]  = {3'd2, 1'b1, mk6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                                   mk6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF)};
        dir_tab[9]  = {3'd2, 1'b1, mk6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
                                   mk6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000)};
        dir_tab[10] = {3'd2, 1'b1, mk6(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                                   mk6(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF)};
        dir_tab[11] = {3'd3, 1'b1, mk6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
                                   mk6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF)};
        dir_tab[12] = {3'd3, 1'b1, mk6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                                   mk6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000)};
        dir_tab[13] = {3'd3, 1'b1, mk6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
                                   mk6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000)};
        dir_tab[14] = {3'd4, 1'b1, mk6(16'h1234, 16'hABCD, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF),
                                   mk6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000)};
        // translation right at the saturation boundary
        dir_tab[15] = {3'd5, 1'b0, mk6(16'h00FF, 16'hFF00, 16'h0000, 16'h0100, 16'hFEFF, 16'h2A00),
                                   96'd0};
        dir_tab[16] = {3'd5, 1'b0, mk6(16'h7FFF, 16'h8000, 16'h4000, 16'h7FFF, 16'h8000, 16'h4000),
                                   96'd0};

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_rows();

        // directed part under light input gaps and heavy output stalls
        src_idle_pct  = 6;
        sink_idle_pct = 73;
        cur = 0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (int'(dir_tab[i].cfg_id) != cur)
            begin
                settle();
                cur = int'(dir_tab[i].cfg_id);
                apply_rows(dir_cfg[cur][0], dir_cfg[cur][1], dir_cfg[cur][2]);
            end
            send_box(dir_tab[i].stim, dir_tab[i].chk, dir_tab[i].want);
        end

        // random part: three idling phases, each through all row modes
        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            src_idle_pct  = (ph == 0) ? 6 : (ph == 1) ? 73 : 0;
            sink_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 6 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                settle();
                apply_rows(rand_row(row_mode_e'(seg)), rand_row(row_mode_e'(seg)),
                           rand_row(row_mode_e'(seg)));
                for (int n = 0; n < SEG_ITEMS; n++)
                    send_box(rand_box(), 1'b0, '0);
            end
        end

        settle();
        err_count += expected_boxes.size();
        $display("summary: %0d boxes sent, %0d bounding boxes checked", item_count, result_count);
        $display("summary: %0d transform settings, three stall patterns", cfg_count);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
